// ===== design/mlfq_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfq_pkg
// Shared types and codes of the multilevel feedback queue scheduler.
// ----------------------------------------------------------------------------
package mlfq_pkg;

    localparam int ID_W    = 4;
    localparam int KIND_W  = 3;
    localparam int LABEL_W = 4;
    localparam int CFG_W   = 16;
    localparam int LIU_W   = 4;

    localparam logic [KIND_W-1:0] KIND_YIELD = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_EXIT  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_BOOST = 3'd3;
    localparam logic [KIND_W-1:0] KIND_IDLE  = 3'd4;

    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_SLICE = 1'b1;

    localparam logic CFG_LEVELS_IN_USE = 1'b0;
    localparam logic CFG_BOOST_PERIOD  = 1'b1;

    localparam logic [LIU_W-1:0] LEVELS_IN_USE_RESET = 4'd3;
    localparam logic [CFG_W-1:0] BOOST_PERIOD_RESET  = 16'd10;

    typedef struct packed {
        logic            operation;
        logic [ID_W-1:0] process_id;
        logic            used_full_slice;
        logic            finishes;
    } sched_in_t;

    typedef struct packed {
        logic [KIND_W-1:0]  event_kind;
        logic [ID_W-1:0]    run_id;
        logic [LABEL_W-1:0] queue_label;
        logic               last;
    } sched_out_t;

    typedef struct packed {
        logic load;
        logic admit;
        logic emit_idle;
        logic boost_start;
        logic boost_next;
        logic boost_rd;
        logic boost_mv;
        logic pop_rd;
        logic pop_wr;
    } dp_cmd_t;

    typedef struct packed {
        logic op_slice;
        logic found_any;
        logic boost_due;
        logic src_done;
        logic src_can_move;
        logic emit_ok;
    } dp_status_t;

endpackage

// ===== design/mlfq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlfq_ctrl
// Sequencer: admit, priority search, boost walk and slice queue move.
// ----------------------------------------------------------------------------
module mlfq_ctrl
    import mlfq_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_SEARCH    = 3'd1;
    localparam logic [2:0] ST_BOOST_CHK = 3'd2;
    localparam logic [2:0] ST_BOOST_MV  = 3'd3;
    localparam logic [2:0] ST_POP_RD    = 3'd4;
    localparam logic [2:0] ST_POP_WR    = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.load  = accept;
                cmd.admit = accept && !status.op_slice;
                if (accept && status.op_slice) begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if (!status.found_any) begin
                    if (status.emit_ok) begin
                        cmd.emit_idle = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end else if (status.boost_due) begin
                    cmd.boost_start = 1'b1;
                    state_next      = ST_BOOST_CHK;
                end else begin
                    cmd.pop_rd = 1'b1;
                    state_next = ST_POP_WR;
                end
            end
            ST_BOOST_CHK: begin
                if (status.src_done) begin
                    state_next = ST_POP_RD;
                end else if (status.src_can_move) begin
                    cmd.boost_rd = 1'b1;
                    state_next   = ST_BOOST_MV;
                end else begin
                    cmd.boost_next = 1'b1;
                end
            end
            ST_BOOST_MV: begin
                if (status.emit_ok) begin
                    cmd.boost_mv = 1'b1;
                    state_next   = ST_BOOST_CHK;
                end
            end
            ST_POP_RD: begin
                cmd.pop_rd = 1'b1;
                state_next = ST_POP_WR;
            end
            ST_POP_WR: begin
                if (status.emit_ok) begin
                    cmd.pop_wr = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/mlfq_datapath.sv =====
// ----------------------------------------------------------------------------
// mlfq_datapath
// Level rings, per-level pointers and counts, slice counter, result register.
// ----------------------------------------------------------------------------
module mlfq_datapath
    import mlfq_pkg::*;
#(
    parameter int MAX_LEVELS = 8,
    parameter int MAX_PROCS  = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  dp_cmd_t          cmd,
    output dp_status_t       status,
    input  sched_in_t        s_data,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             m_ready,
    output logic             m_valid,
    output sched_out_t       m_data
);

    localparam int PW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW    = $clog2(MAX_PROCS + 1);
    localparam int LVW   = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int NLW   = $clog2(MAX_LEVELS + 1);
    localparam int DEPTH = MAX_LEVELS * MAX_PROCS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [ID_W-1:0]  store_mem [DEPTH];
    logic [ID_W-1:0]  rd_data_reg;

    logic [PW-1:0]    head_reg  [MAX_LEVELS];
    logic [PW-1:0]    tail_reg  [MAX_LEVELS];
    logic [CW-1:0]    count_reg [MAX_LEVELS];
    logic [PW-1:0]    head_next [MAX_LEVELS];
    logic [PW-1:0]    tail_next [MAX_LEVELS];
    logic [CW-1:0]    count_next[MAX_LEVELS];

    logic [LIU_W-1:0] levels_in_use_reg;
    logic [CFG_W-1:0] boost_period_reg;
    logic [CFG_W-1:0] slices_reg;
    logic [NLW-1:0]   src_reg;
    logic [LVW-1:0]   lv_reg;
    logic             full_reg;
    logic             fin_reg;
    logic             m_valid_reg;
    sched_out_t       m_data_reg;

    logic [NLW-1:0]   nlev;
    logic             found_any;
    logic [LVW-1:0]   found_lv;
    logic [LVW-1:0]   src_lv;
    logic [NLW-1:0]   lv_up;
    logic             demote_ok;
    logic             top_full;
    logic             emit_ok;

    logic             pop_en, push_en;
    logic [LVW-1:0]   pop_lv, push_lv;
    logic [ID_W-1:0]  push_id;
    logic             rd_en;
    logic [LVW-1:0]   rd_lv;
    sched_out_t       result;
    logic             emit_en;

    function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
        return (p == PW'(MAX_PROCS - 1)) ? '0 : PW'(p + PW'(1));
    endfunction

    function automatic logic [AW-1:0] addr_of(input logic [LVW-1:0] lv,
                                              input logic [PW-1:0] ptr);
        return AW'(AW'(lv) * AW'(MAX_PROCS) + AW'(ptr));
    endfunction

    always_comb begin
        if (levels_in_use_reg == '0) begin
            nlev = NLW'(1);
        end else if (32'(levels_in_use_reg) > MAX_LEVELS) begin
            nlev = NLW'(MAX_LEVELS);
        end else begin
            nlev = NLW'(levels_in_use_reg);
        end
    end

    always_comb begin
        found_any = 1'b0;
        found_lv  = '0;
        for (int l = MAX_LEVELS - 1; l >= 0; l--) begin
            if (NLW'(l) < nlev && count_reg[l] != '0) begin
                found_any = 1'b1;
                found_lv  = LVW'(l);
            end
        end
    end

    assign src_lv    = src_reg[LVW-1:0];
    assign lv_up     = NLW'(lv_reg) + NLW'(1);
    assign top_full  = (count_reg[0] == CW'(MAX_PROCS));
    assign demote_ok = (lv_up < nlev) && (count_reg[lv_up[LVW-1:0]] != CW'(MAX_PROCS));
    assign emit_ok   = !m_valid_reg || m_ready;

    assign status.op_slice     = (s_data.operation == OP_SLICE);
    assign status.found_any    = found_any;
    assign status.boost_due    = (slices_reg >= boost_period_reg);
    assign status.src_done     = (src_reg >= nlev);
    assign status.src_can_move = (src_reg < nlev) && (count_reg[src_lv] != '0) && !top_full;
    assign status.emit_ok      = emit_ok;

    // queue moves and result selection
    always_comb begin
        pop_en  = 1'b0;
        pop_lv  = '0;
        push_en = 1'b0;
        push_lv = '0;
        push_id = rd_data_reg;
        rd_en   = 1'b0;
        rd_lv   = found_lv;
        emit_en = 1'b0;
        result  = '0;
        if (cmd.admit) begin
            push_en = !top_full;
            push_id = s_data.process_id;
        end
        if (cmd.pop_rd) begin
            rd_en = 1'b1;
        end
        if (cmd.boost_rd) begin
            rd_en = 1'b1;
            rd_lv = src_lv;
        end
        if (cmd.emit_idle) begin
            emit_en            = 1'b1;
            result.event_kind  = KIND_IDLE;
            result.last        = 1'b1;
        end
        if (cmd.boost_mv) begin
            pop_en             = 1'b1;
            pop_lv             = src_lv;
            push_en            = 1'b1;
            emit_en            = 1'b1;
            result.event_kind  = KIND_BOOST;
            result.run_id      = rd_data_reg;
            result.queue_label = LABEL_W'(nlev);
        end
        if (cmd.pop_wr) begin
            pop_en        = 1'b1;
            pop_lv        = lv_reg;
            emit_en       = 1'b1;
            result.run_id = rd_data_reg;
            result.last   = 1'b1;
            if (fin_reg) begin
                result.event_kind = KIND_EXIT;
            end else if (full_reg && demote_ok) begin
                push_en            = 1'b1;
                push_lv            = lv_up[LVW-1:0];
                result.event_kind  = KIND_FULL;
                result.queue_label = LABEL_W'(nlev - lv_up);
            end else begin
                push_en            = 1'b1;
                push_lv            = lv_reg;
                result.event_kind  = full_reg ? KIND_FULL : KIND_YIELD;
                result.queue_label = LABEL_W'(nlev - NLW'(lv_reg));
            end
        end
    end

    always_comb begin
        for (int l = 0; l < MAX_LEVELS; l++) begin
            head_next[l]  = head_reg[l];
            tail_next[l]  = tail_reg[l];
            count_next[l] = count_reg[l];
            if (pop_en && pop_lv == LVW'(l)) begin
                head_next[l] = ring_next(head_reg[l]);
            end
            if (push_en && push_lv == LVW'(l)) begin
                tail_next[l] = ring_next(tail_reg[l]);
            end
            if ((pop_en && pop_lv == LVW'(l)) && !(push_en && push_lv == LVW'(l))) begin
                count_next[l] = count_reg[l] - CW'(1);
            end else if (!(pop_en && pop_lv == LVW'(l)) && (push_en && push_lv == LVW'(l))) begin
                count_next[l] = count_reg[l] + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_en) begin
            store_mem[addr_of(push_lv, tail_reg[push_lv])] <= push_id;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[addr_of(rd_lv, head_reg[rd_lv])];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int l = 0; l < MAX_LEVELS; l++) begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
            slices_reg        <= '0;
            levels_in_use_reg <= LEVELS_IN_USE_RESET;
            boost_period_reg  <= BOOST_PERIOD_RESET;
            m_valid_reg       <= 1'b0;
        end else begin
            for (int l = 0; l < MAX_LEVELS; l++) begin
                head_reg[l]  <= head_next[l];
                tail_reg[l]  <= tail_next[l];
                count_reg[l] <= count_next[l];
            end
            if (cmd.boost_start) begin
                slices_reg <= '0;
            end else if (cmd.pop_wr && slices_reg != '1) begin
                slices_reg <= slices_reg + CFG_W'(1);
            end
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_LEVELS_IN_USE: levels_in_use_reg <= cfg_wdata[LIU_W-1:0];
                    CFG_BOOST_PERIOD:  boost_period_reg  <= cfg_wdata;
                    default:           levels_in_use_reg <= levels_in_use_reg;
                endcase
            end
            if (emit_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            full_reg <= s_data.used_full_slice;
            fin_reg  <= s_data.finishes;
        end
        if (cmd.boost_start) begin
            src_reg <= NLW'(1);
        end else if (cmd.boost_next || cmd.boost_mv) begin
            if (cmd.boost_next) begin
                src_reg <= src_reg + NLW'(1);
            end
        end
        if (cmd.pop_rd) begin
            lv_reg <= found_lv;
        end
        if (emit_en) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/multilevel_feedback_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// multilevel_feedback_scheduler_unit
// Multilevel feedback queue scheduler over ring-buffered priority levels.
//
//   channel  dir  handshake          payload
//   s_       in   s_valid/s_ready    sched_in_t  (admit or slice)
//   m_       out  m_valid/m_ready    sched_out_t (event results)
//   cfg_     in   cfg_wr_en          cfg_index, cfg_wdata
//
// Admit: taken in idle, s_ready stays high. Slice: accept, priority
// search with ring read, queue move and result; the level store read
// is registered. A boost first moves processes of the lower levels to
// the top level while it has room. Result stalls hold the sequencer in place.
// Reset clears pointers, counts and the slice counter; no clearing pass.
// ----------------------------------------------------------------------------
module multilevel_feedback_scheduler_unit
    import mlfq_pkg::*;
#(
    parameter int MAX_LEVELS = 8,
    parameter int MAX_PROCS  = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  sched_in_t        s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output sched_out_t       m_data,
    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    dp_cmd_t    cmd;
    dp_status_t status;

    mlfq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    mlfq_datapath #(
        .MAX_LEVELS (MAX_LEVELS),
        .MAX_PROCS  (MAX_PROCS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_data    (s_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

endmodule

// ===== design/mlfq_checker.sv =====
// ----------------------------------------------------------------------------
// mlfq_checker
// Port-level checks on the scheduler's result stream.
// ----------------------------------------------------------------------------
module mlfq_checker
    import mlfq_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input sched_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_idle_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == KIND_IDLE |->
            m_data.last && m_data.run_id == '0 && m_data.queue_label == '0)
        else $error("malformed idle result");

    a_exit_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == KIND_EXIT |->
            m_data.last && m_data.queue_label == '0)
        else $error("malformed exit result");

    a_boost_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.event_kind == KIND_BOOST |-> !m_data.last)
        else $error("boost transfer flagged last");

endmodule

bind multilevel_feedback_scheduler_unit mlfq_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== bench/tb_multilevel_feedback_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// tb_multilevel_feedback_scheduler_unit
// Self-checking bench for the multilevel feedback queue scheduler. A directed
// table covers the idle slice, exits, demotion, bottom-level rotation, boosts
// and out-of-range level counts. Random phases with varied register settings
// follow. Results are checked against an in-bench scheduler model, or a table
// literal for some rows. Random gaps and stalls are applied on both channels.
// ----------------------------------------------------------------------------
module tb_multilevel_feedback_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import mlfq_pkg::*;

    localparam int NUM_LEVELS   = 8;
    localparam int RING         = 16;
    localparam int RESET_CYCLES = 8;
    localparam int SETTLE       = 8;
    localparam int TAIL         = 24;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 33;
    localparam int MAX_REPORTS  = 10;
    localparam int DIR_N        = 26;
    localparam longint TIMEOUT_NS = 20_000_000;

    localparam sched_out_t EV_NONE = '0;
    localparam sched_out_t EV_IDLE = '{KIND_IDLE, 4'd0, 4'd0, 1'b1};

    typedef enum {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct {
        row_kind_e   kind;
        sched_in_t   item;
        bit          lit_on;
        sched_out_t  lit;
        logic [15:0] cfg_levels;
        logic [15:0] cfg_period;
    } stim_row_t;

    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    sched_in_t        s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    sched_out_t       m_data;
    logic             cfg_wr_en = 1'b0;
    logic             cfg_index = CFG_LEVELS_IN_USE;
    logic [CFG_W-1:0] cfg_wdata = '0;

    // scheduler model state
    logic [ID_W-1:0] lvl_ring [NUM_LEVELS][RING];
    logic [3:0]      lvl_rd   [NUM_LEVELS] = '{default: '0};
    logic [3:0]      lvl_wr   [NUM_LEVELS] = '{default: '0};
    int unsigned     lvl_cnt  [NUM_LEVELS] = '{default: 0};
    int unsigned     slices_run = 0;
    logic [LIU_W-1:0] cur_levels = LEVELS_IN_USE_RESET;
    logic [CFG_W-1:0] cur_period = BOOST_PERIOD_RESET;

    sched_out_t step_events [$];
    sched_out_t exp_events [$];
    int         err_count = 0;

    stim_row_t dir_rows [DIR_N] = '{
        '{ROW_ITEM, '{OP_SLICE, 4'hF, 1'b1, 1'b1}, 1'b1, EV_IDLE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_ADMIT, 4'h0, 1'b0, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_ADMIT, 4'hF, 1'b1, 1'b1}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'h0, 1'b1, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'h5, 1'b0, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'hA, 1'b1, 1'b1}, 1'b1,
          '{KIND_EXIT, 4'hF, 4'd0, 1'b1}, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'h3, 1'b1, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'hC, 1'b1, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'h9, 1'b0, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_ADMIT, 4'h5, 1'b0, 1'b1}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'h6, 1'b1, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'h1, 1'b0, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'h2, 1'b0, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'h4, 1'b1, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'h8, 1'b0, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_CFG,  '{OP_ADMIT, 4'h0, 1'b0, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_ADMIT, 4'h7, 1'b1, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'hE, 1'b1, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'hB, 1'b0, 1'b1}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_CFG,  '{OP_ADMIT, 4'h0, 1'b0, 1'b0}, 1'b0, EV_NONE, 16'hFFFF, 16'hFFFF},
        '{ROW_ITEM, '{OP_SLICE, 4'hD, 1'b1, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'h7, 1'b1, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'hA, 1'b0, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_CFG,  '{OP_ADMIT, 4'h0, 1'b0, 1'b0}, 1'b0, EV_NONE, 16'd8, 16'd1},
        '{ROW_ITEM, '{OP_SLICE, 4'h5, 1'b1, 1'b0}, 1'b0, EV_NONE, 16'd0, 16'd0},
        '{ROW_ITEM, '{OP_SLICE, 4'h0, 1'b0, 1'b1}, 1'b0, EV_NONE, 16'd0, 16'd0}
    };

    multilevel_feedback_scheduler_unit #(
        .MAX_LEVELS(NUM_LEVELS),
        .MAX_PROCS (RING)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_multilevel_feedback_scheduler_unit: done, errors");
        $finish;
    end

    function automatic bit ring_push(int lv, logic [ID_W-1:0] id);
        if (lvl_cnt[lv] >= RING) return 1'b0;
        lvl_ring[lv][lvl_wr[lv]] = id;
        lvl_wr[lv] = lvl_wr[lv] + 1'b1;
        lvl_cnt[lv]++;
        return 1'b1;
    endfunction

    function automatic logic [ID_W-1:0] ring_pop(int lv);
        logic [ID_W-1:0] id;
        id = lvl_ring[lv][lvl_rd[lv]];
        lvl_rd[lv] = lvl_rd[lv] + 1'b1;
        lvl_cnt[lv]--;
        return id;
    endfunction

    function automatic int top_level(int nlev);
        for (int i = 0; i < nlev; i++) begin
            if (lvl_cnt[i] != 0) return i;
        end
        return -1;
    endfunction

    function automatic void add_event(sched_out_t ev);
        step_events.insert(step_events.size(), ev);
    endfunction

    // results of one input item land in step_events
    function automatic void sched_step(sched_in_t it);
        int nlev;
        int lv;
        logic [ID_W-1:0] id;
        step_events.delete();
        if (cur_levels == 0) nlev = 1;
        else if (cur_levels > NUM_LEVELS) nlev = NUM_LEVELS;
        else nlev = int'(cur_levels);
        if (it.operation == OP_ADMIT) begin
            void'(ring_push(0, it.process_id));
            return;
        end
        lv = top_level(nlev);
        if (lv < 0) begin
            add_event(EV_IDLE);
            return;
        end
        if (slices_run >= cur_period) begin
            for (int src = 1; src < nlev; src++) begin
                while (lvl_cnt[src] != 0 && lvl_cnt[0] < RING) begin
                    id = ring_pop(src);
                    void'(ring_push(0, id));
                    add_event(sched_out_t'{KIND_BOOST, id, LABEL_W'(nlev), 1'b0});
                end
            end
            slices_run = 0;
            lv = top_level(nlev);
        end
        id = ring_pop(lv);
        if (slices_run < 16'hFFFF) slices_run++;
        if (it.finishes) begin
            add_event(sched_out_t'{KIND_EXIT, id, 4'd0, 1'b1});
        end else if (it.used_full_slice) begin
            if (lv + 1 < nlev && ring_push(lv + 1, id)) begin
                add_event(sched_out_t'{KIND_FULL, id, LABEL_W'(nlev - lv - 1), 1'b1});
            end else begin
                void'(ring_push(lv, id));
                add_event(sched_out_t'{KIND_FULL, id, LABEL_W'(nlev - lv), 1'b1});
            end
        end else begin
            void'(ring_push(lv, id));
            add_event(sched_out_t'{KIND_YIELD, id, LABEL_W'(nlev - lv), 1'b1});
        end
    endfunction

    task automatic drain_events();
        while (exp_events.size() != 0) @(posedge aclk);
    endtask

    task automatic send_item(sched_in_t it, bit lit_on, sched_out_t lit, bit quiet);
        int gap;
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60) gap = 0;
        else if (r < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(10, 30);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sched_step(it);
        if (lit_on) begin
            exp_events.insert(exp_events.size(), lit);
        end else begin
            foreach (step_events[i]) exp_events.insert(exp_events.size(), step_events[i]);
        end
    endtask

    // only while idle: no transfer pending, no result outstanding
    task automatic write_cfg(logic [15:0] lv_w, logic [15:0] per_w);
        s_valid <= 1'b0;
        drain_events();
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_LEVELS_IN_USE;
        cfg_wdata <= lv_w;
        @(posedge aclk);
        cur_levels = lv_w[LIU_W-1:0];
        cfg_index <= CFG_BOOST_PERIOD;
        cfg_wdata <= per_w;
        @(posedge aclk);
        cur_period = per_w;
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : ready_gen
        int run_len;
        int stall_len;
        int r;
        forever begin
            run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 12);
            r = $urandom_range(0, 99);
            if (r < 55) stall_len = 0;
            else if (r < 90) stall_len = $urandom_range(1, 3);
            else stall_len = $urandom_range(10, 40);
            m_ready <= 1'b1;
            repeat (run_len) @(posedge aclk);
            if (stall_len > 0) begin
                m_ready <= 1'b0;
                repeat (stall_len) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        sched_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (exp_events.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected transfer: kind %0d id %0d label %0d last %0d",
                             m_data.event_kind, m_data.run_id, m_data.queue_label,
                             m_data.last);
            end else begin
                want = exp_events.pop_front();
                if (m_data.event_kind !== want.event_kind || m_data.run_id !== want.run_id ||
                    m_data.queue_label !== want.queue_label || m_data.last !== want.last) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                 want.event_kind, want.run_id, want.queue_label, want.last,
                                 m_data.event_kind, m_data.run_id, m_data.queue_label,
                                 m_data.last);
                end
            end
        end
    end

    initial begin : stimulus
        sched_in_t   it;
        int          lv;
        logic [15:0] per;
        int          p_admit;
        int          p_full;
        int          p_fin;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < DIR_N; r++) begin
            if (dir_rows[r].kind == ROW_CFG)
                write_cfg(dir_rows[r].cfg_levels, dir_rows[r].cfg_period);
            else
                send_item(dir_rows[r].item, dir_rows[r].lit_on, dir_rows[r].lit, 1'b0);
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin lv = 8; per = 16'd10; end
                1: begin lv = 1; per = 16'd0; end
                2: begin lv = 3; per = 16'hFFFF; end
                3: begin lv = 0; per = 16'd1; end
                4: begin lv = 15; per = 16'($urandom_range(2, 12)); end
                5: begin lv = 8; per = 16'hFFFF; end
                6: begin lv = 2; per = 16'($urandom_range(1, 40)); end
                7: begin lv = $urandom_range(1, 8); per = 16'($urandom_range(0, 20)); end
                default: begin lv = $urandom_range(0, 15); per = 16'($urandom); end
            endcase
            write_cfg({12'($urandom), 4'(lv)}, per);
            // admit-heavy phases fill the rings so full levels get exercised
            if (ph == 2 || ph == 5 || ph == 8) begin
                p_admit = 70;
                p_full  = 85;
                p_fin   = 2;
            end else begin
                p_admit = $urandom_range(35, 60);
                p_full  = $urandom_range(20, 80);
                p_fin   = $urandom_range(5, 25);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 4 && n == PHASE_ITEMS / 2) begin
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    drain_events();
                end
                it.operation       = ($urandom_range(0, 99) < p_admit) ? OP_ADMIT : OP_SLICE;
                it.process_id      = 4'($urandom_range(0, 15));
                it.used_full_slice = ($urandom_range(0, 99) < p_full);
                it.finishes        = ($urandom_range(0, 99) < p_fin);
                send_item(it, 1'b0, EV_NONE, ph == 2);
            end
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        drain_events();
        repeat (TAIL) @(posedge aclk);
        if (err_count == 0 && exp_events.size() == 0) begin
            $display("tb_multilevel_feedback_scheduler_unit: done, clean");
        end else begin
            $display("tb_multilevel_feedback_scheduler_unit: done, errors");
        end
        $finish;
    end

endmodule
